// ===== rtl/iec61937_burst_deframer_top_assert.svh =====
// Assertion macros for the burst deframer checker.
// Each macro expands to one labelled concurrent assertion on i_clk,
// disabled while i_rst_n is low.
`ifndef IEC61937_BURST_DEFRAMER_TOP_ASSERT_SVH
`define IEC61937_BURST_DEFRAMER_TOP_ASSERT_SVH

// Same-cycle implication
`define IECBD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("deframer check failed");

// Next-cycle implication
`define IECBD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("deframer check failed");

`endif

// ===== rtl/iecbd_pkg.sv =====
// Shared types and constants for the IEC 61937 burst deframer.
// No dependencies; imported by every other RTL source file except the assertion header.
`default_nettype none

package iecbd_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int TYPE_W     = 7;
    localparam int LEN_W      = 13;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    // Preamble words and special data type
    localparam logic [SAMPLE_W-1:0] SYNC_A        = 16'hF872;
    localparam logic [SAMPLE_W-1:0] SYNC_B        = 16'h4E1F;
    localparam logic [SAMPLE_W-1:0] ZERO_WORD     = 16'h0000;
    localparam logic [TYPE_W-1:0]   TYPE_EXTENDED = 7'd31;

    // Configuration register
    localparam logic                CFG_IDX_ACC_TYPE = 1'b0;
    localparam logic [TYPE_W-1:0]   ACC_TYPE_RESET   = 7'd1;

    // Byte count codes
    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_ONE  = 2'd1;
    localparam logic [1:0] CNT_TWO  = 2'd2;

    typedef enum logic [3:0] {
        PH_Z0   = 4'd0,
        PH_Z1   = 4'd1,
        PH_Z2   = 4'd2,
        PH_Z3   = 4'd3,
        PH_SA   = 4'd4,
        PH_SB   = 4'd5,
        PH_TYPE = 4'd6,
        PH_LEN  = 4'd7,
        PH_DATA = 4'd8
    } t_phase;

    typedef struct packed {
        logic              locked;
        logic [1:0]        byte_count;
        logic [7:0]        first_byte;
        logic [7:0]        second_byte;
        logic              burst_end;
        logic [TYPE_W-1:0] burst_type;
        logic [LEN_W-1:0]  burst_bytes;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/iecbd_if.sv =====
// Stream interfaces for the deframer: sample input and result output.
// Depends on iecbd_pkg for field widths.
`default_nettype none

interface iecbd_in_if import iecbd_pkg::*; ;
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface iecbd_out_if import iecbd_pkg::*; ;
    logic              valid;
    logic              ready;
    logic              locked;
    logic [1:0]        byte_count;
    logic [7:0]        first_byte;
    logic [7:0]        second_byte;
    logic              burst_end;
    logic [TYPE_W-1:0] burst_type;
    logic [LEN_W-1:0]  burst_bytes;

    modport source (output valid, output locked, output byte_count, output first_byte,
                    output second_byte, output burst_end, output burst_type,
                    output burst_bytes, input ready);
    modport sink   (input valid, input locked, input byte_count, input first_byte,
                    input second_byte, input burst_end, input burst_type,
                    input burst_bytes, output ready);
endinterface

`default_nettype wire

// ===== rtl/iec61937_burst_deframer_top.sv =====
// IEC 61937 burst deframer, top level.
// A result is written into the output queue on its sample transfer and offered from there in order.
// Throughput: one sample per cycle while the result queue is not full; the state machine steps once per transfer.
// A two-entry result queue keeps input ready while one result is stalled.
// Reset (synchronous, active low) returns to the first zero hunt, clears type,
// length and byte count, empties the queue and sets accepted_type to 1.
`default_nettype none

module iec61937_burst_deframer_top import iecbd_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    iecbd_in_if.sink                   i_in_ch,
    iecbd_out_if.source                o_out_ch,
    input  wire logic                  i_psel,
    input  wire logic                  i_penable,
    input  wire logic                  i_pwrite,
    input  wire logic [CFG_ADDR_W-1:0] i_paddr,
    input  wire logic [CFG_DATA_W-1:0] i_pwdata,
    output logic      [CFG_DATA_W-1:0] o_prdata,
    output logic                       o_pready
);

    logic [TYPE_W-1:0] w_accepted_type;
    logic              w_full;
    logic              w_step;
    logic              w_pop;
    logic              w_out_valid;
    t_result           w_core_res;
    t_result           w_out_res;

    iecbd_cfg u_cfg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_psel          (i_psel),
        .i_penable       (i_penable),
        .i_pwrite        (i_pwrite),
        .i_paddr         (i_paddr),
        .i_pwdata        (i_pwdata),
        .o_prdata        (o_prdata),
        .o_pready        (o_pready),
        .o_accepted_type (w_accepted_type)
    );

    // input transfer
    assign i_in_ch.ready = ~w_full;
    assign w_step        = i_in_ch.valid & ~w_full;

    iecbd_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (w_step),
        .i_sample        (i_in_ch.sample),
        .i_accepted_type (w_accepted_type),
        .o_result        (w_core_res)
    );

    // output transfer
    assign w_pop = w_out_valid & o_out_ch.ready;

    iecbd_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_step),
        .i_data  (w_core_res),
        .o_full  (w_full),
        .o_valid (w_out_valid),
        .i_pop   (w_pop),
        .o_data  (w_out_res)
    );

    assign o_out_ch.valid       = w_out_valid;
    assign o_out_ch.locked      = w_out_res.locked;
    assign o_out_ch.byte_count  = w_out_res.byte_count;
    assign o_out_ch.first_byte  = w_out_res.first_byte;
    assign o_out_ch.second_byte = w_out_res.second_byte;
    assign o_out_ch.burst_end   = w_out_res.burst_end;
    assign o_out_ch.burst_type  = w_out_res.burst_type;
    assign o_out_ch.burst_bytes = w_out_res.burst_bytes;

endmodule

`default_nettype wire

// ===== rtl/iecbd_cfg.sv =====
// APB-style configuration register block: holds accepted_type.
// Depends on iecbd_pkg.
`default_nettype none

module iecbd_cfg import iecbd_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_psel,
    input  wire logic                  i_penable,
    input  wire logic                  i_pwrite,
    input  wire logic [CFG_ADDR_W-1:0] i_paddr,
    input  wire logic [CFG_DATA_W-1:0] i_pwdata,
    output logic      [CFG_DATA_W-1:0] o_prdata,
    output logic                       o_pready,
    output logic      [TYPE_W-1:0]     o_accepted_type
);

    logic              w_acc_wr;
    logic [TYPE_W-1:0] r_accepted_type;
    logic              w_sel_acc;

    // word index lives in paddr[2]; anything but index 0 is ignored
    assign w_sel_acc = (i_paddr[2] == CFG_IDX_ACC_TYPE);
    assign w_acc_wr  = i_psel & i_penable & i_pwrite & w_sel_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accepted_type <= ACC_TYPE_RESET;
        end else if (w_acc_wr) begin
            r_accepted_type <= i_pwdata[TYPE_W-1:0];
        end
    end

    // read-back
    assign o_prdata = w_sel_acc ? {{(CFG_DATA_W-TYPE_W){1'b0}}, r_accepted_type}
                                : {CFG_DATA_W{1'b0}};
    assign o_pready        = 1'b1;
    assign o_accepted_type = r_accepted_type;

endmodule

`default_nettype wire

// ===== rtl/iecbd_core.sv =====
// Deframer state machine: preamble hunt, type and length capture, payload
// byte extraction. Produces one result per transfer. Depends on iecbd_pkg.
`default_nettype none

module iecbd_core import iecbd_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_step,
    input  wire logic [SAMPLE_W-1:0] i_sample,
    input  wire logic [TYPE_W-1:0]   i_accepted_type,
    output t_result                  o_result
);

    t_phase            r_phase,        n_phase;
    logic [TYPE_W-1:0] r_cur_type,     n_cur_type;
    logic [LEN_W-1:0]  r_len_bytes,    n_len_bytes;
    logic [LEN_W-1:0]  r_bytes_seen,   n_bytes_seen;

    logic [SAMPLE_W-1:0] w_word;
    logic [1:0]          w_count;
    logic [7:0]          w_b0;
    logic [7:0]          w_b1;
    logic                w_last;
    logic [LEN_W-1:0]    w_seen_next;
    logic                w_two_left;

    // little-endian to big-endian
    assign w_word = {i_sample[7:0], i_sample[15:8]};

    // payload byte extraction (output side)
    always_comb begin
        w_two_left  = ({1'b0, r_len_bytes} >= ({1'b0, r_bytes_seen} + 14'd2));
        w_count     = CNT_NONE;
        w_b0        = 8'h00;
        w_b1        = 8'h00;
        w_seen_next = r_bytes_seen;
        w_last      = 1'b0;
        if (r_phase == PH_DATA) begin
            w_b0 = w_word[15:8];
            if (w_two_left) begin
                w_b1    = w_word[7:0];
                w_count = CNT_TWO;
            end else begin
                w_count = CNT_ONE;
            end
            w_seen_next = r_bytes_seen + {{(LEN_W-2){1'b0}}, w_count};
            w_last      = (w_seen_next == r_len_bytes);
        end
    end

    // next state
    always_comb begin
        n_phase      = r_phase;
        n_cur_type   = r_cur_type;
        n_len_bytes  = r_len_bytes;
        n_bytes_seen = r_bytes_seen;
        case (r_phase)
            PH_Z0: begin
                if (w_word == ZERO_WORD) n_phase = PH_Z1;
            end
            PH_Z1: n_phase = (w_word == ZERO_WORD) ? PH_Z2 : PH_Z0;
            PH_Z2: n_phase = (w_word == ZERO_WORD) ? PH_Z3 : PH_Z0;
            PH_Z3: n_phase = (w_word == ZERO_WORD) ? PH_SA : PH_Z0;
            PH_SA: begin
                // extra zero words keep waiting for the first sync word
                if (w_word == SYNC_A) begin
                    n_phase = PH_SB;
                end else if (w_word != ZERO_WORD) begin
                    n_phase = PH_Z0;
                end
            end
            PH_SB: n_phase = (w_word == SYNC_B) ? PH_TYPE : PH_Z0;
            PH_TYPE: begin
                n_cur_type = w_word[TYPE_W-1:0];
                n_phase    = (w_word[TYPE_W-1:0] == TYPE_EXTENDED) ? PH_Z0 : PH_LEN;
            end
            PH_LEN: begin
                if (r_cur_type == i_accepted_type) begin
                    n_bytes_seen = '0;
                    n_len_bytes  = w_word[15:3];
                    n_phase      = (w_word[15:3] == '0) ? PH_Z0 : PH_DATA;
                end else begin
                    n_phase = PH_Z0;
                end
            end
            PH_DATA: begin
                n_bytes_seen = w_seen_next;
                if (w_last) n_phase = PH_Z0;
            end
            default: n_phase = PH_Z0;
        endcase
    end

    // state registers, advanced once per accepted transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_Z0;
            r_cur_type   <= '0;
            r_len_bytes  <= '0;
            r_bytes_seen <= '0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_cur_type   <= n_cur_type;
            r_len_bytes  <= n_len_bytes;
            r_bytes_seen <= n_bytes_seen;
        end
    end

    // result for this transfer
    always_comb begin
        o_result.locked      = (n_phase == PH_TYPE) || (n_phase == PH_LEN) ||
                               (n_phase == PH_DATA);
        o_result.byte_count  = w_count;
        o_result.first_byte  = w_b0;
        o_result.second_byte = w_b1;
        o_result.burst_end   = w_last;
        o_result.burst_type  = n_cur_type;
        o_result.burst_bytes = n_len_bytes;
    end

endmodule

`default_nettype wire

// ===== rtl/iecbd_outq.sv =====
// Two-entry result queue between the core and the output channel, so a
// transfer can be taken while a result is stalled. Depends on iecbd_pkg.
`default_nettype none

module iecbd_outq import iecbd_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_data,
    output logic         o_full,
    output logic         o_valid,
    input  wire logic    i_pop,
    output t_result      o_data
);

    t_result    r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_comb begin
        n_count = r_count;
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 2'd1;
            2'b01:   n_count = r_count - 2'd1;
            default: n_count = r_count;
        endcase
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) r_wr_ptr <= ~r_wr_ptr;
            if (i_pop)  r_rd_ptr <= ~r_rd_ptr;
            r_count <= n_count;
        end
    end

    assign o_full  = r_count[1];
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];

endmodule

`default_nettype wire

// ===== rtl/iecbd_checker.sv =====
// Port-level checks for the burst deframer output channel, bound to the top.
// Depends on iecbd_pkg and the assertion macro header.
`default_nettype none

`include "iec61937_burst_deframer_top_assert.svh"

module iecbd_checker import iecbd_pkg::*; (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_out_valid,
    input wire logic             i_out_ready,
    input wire logic             i_locked,
    input wire logic [1:0]       i_byte_count,
    input wire logic [7:0]       i_second_byte,
    input wire logic             i_burst_end
);

    // never more than two bytes per result
    `IECBD_ASSERT_NOW(a_count_range, i_out_valid, i_byte_count != 2'd3)
    // end of burst carries a byte and drops lock
    `IECBD_ASSERT_NOW(a_end_unlocks, i_out_valid && i_burst_end,
                      (i_byte_count != CNT_NONE) && !i_locked)
    // a single byte leaves the second byte clear
    `IECBD_ASSERT_NOW(a_single_byte, i_out_valid && (i_byte_count == CNT_ONE),
                      i_second_byte == 8'h00)
    // a stalled result stays offered
    `IECBD_ASSERT_NEXT(a_hold, i_out_valid && !i_out_ready, i_out_valid)

endmodule

bind iec61937_burst_deframer_top iecbd_checker u_iecbd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out_ch.valid),
    .i_out_ready   (o_out_ch.ready),
    .i_locked      (o_out_ch.locked),
    .i_byte_count  (o_out_ch.byte_count),
    .i_second_byte (o_out_ch.second_byte),
    .i_burst_end   (o_out_ch.burst_end)
);

`default_nettype wire
